// ===== design/drfp_pkg.sv =====
// ----------------------------------------------------------------------------
// drfp_pkg
// Shared types, character constants and the decimal residue helper for the
// decimal reply frame parser.
// ----------------------------------------------------------------------------
package drfp_pkg;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_TERM  = 8'h00;

	// One classified byte. digit is rx_byte - '0' as a 9-bit two's complement
	// value, so that sign extension reproduces the 32-bit wrap.
	typedef struct packed {
		logic       is_term;
		logic       is_colon;
		logic [8:0] digit;
	} item_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} q_stat_t;

	typedef struct packed {
		logic pop_term;
		logic check_pop;
		logic res_vld;
	} bk_status_t;

	// s mod 10: 16^k mod 10 = 6 for k >= 1, so fold the upper nibbles with
	// weight 6, then reduce the small sum by reciprocal multiply (x < 1029).
	function automatic logic [3:0] mod10(input logic [31:0] s);
		logic [6:0]  hi_sum;
		logic [9:0]  x;
		logic [17:0] prod;
		logic [9:0]  q10;
		hi_sum = '0;
		for (int k = 1; k < 8; k++) begin
			hi_sum = hi_sum + 7'(s[4*k +: 4]);
		end
		x    = 10'(hi_sum) * 10'd6 + 10'(s[3:0]);
		prod = 18'(x) * 18'd205;
		q10  = 10'(prod[17:11]) * 10'd10;
		return 4'(x - q10);
	endfunction

endpackage

// ===== design/drfp_front.sv =====
// ----------------------------------------------------------------------------
// drfp_front
// Input stage: accepts one byte per cycle unless stalled by a full queue,
// classifies it and pushes it into the queue.
// ----------------------------------------------------------------------------
module drfp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        rx_byte,
	input  drfp_pkg::q_stat_t q_stat,
	output logic              push,
	output drfp_pkg::item_t   item
);

	logic            valid_s1;
	drfp_pkg::item_t item_s1;
	logic            load;

	assign in_stall = valid_s1 && q_stat.full;
	assign push     = valid_s1 && !q_stat.full;
	assign load     = in_valid && !in_stall;
	assign item     = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// classify
	always_ff @(posedge clk) begin
		if (load) begin
			item_s1.is_term  <= (rx_byte == drfp_pkg::CH_TERM);
			item_s1.is_colon <= (rx_byte == drfp_pkg::CH_COLON);
			item_s1.digit    <= {1'b0, rx_byte} - {1'b0, drfp_pkg::CH_ZERO};
		end
	end

endmodule

// ===== design/drfp_queue.sv =====
// ----------------------------------------------------------------------------
// drfp_queue
// Small FIFO of classified bytes between the front and back stages.
// ----------------------------------------------------------------------------
module drfp_queue #(
	parameter int DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  drfp_pkg::item_t   push_item,
	input  logic              pop,
	output drfp_pkg::item_t   head,
	output drfp_pkg::q_stat_t q_stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	drfp_pkg::item_t mem [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign head             = mem[rd_ptr_q];
	assign q_stat.full      = (count_q == CW'(DEPTH));
	assign q_stat.not_empty = (count_q != '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/drfp_back.sv =====
// ----------------------------------------------------------------------------
// drfp_back
// Frame state machine: accumulates type and value, checks the checksum
// digit and registers one result per terminator.
// ----------------------------------------------------------------------------
module drfp_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  drfp_pkg::item_t      head,
	input  drfp_pkg::q_stat_t    q_stat,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 frame_ok,
	output logic [7:0]           msg_type,
	output logic [31:0]          msg_value,
	output drfp_pkg::bk_status_t status
);

	typedef enum logic [4:0] {
		PH_TYPE  = 5'b00001,
		PH_VALUE = 5'b00010,
		PH_CHECK = 5'b00100,
		PH_END   = 5'b01000,
		PH_FAULT = 5'b10000
	} phase_t;

	phase_t      phase_q;
	logic [7:0]  type_q;
	logic [31:0] value_q;
	logic [31:0] sum_q;
	logic        sum_vld_q;
	logic [3:0]  res_q;
	logic        res_vld_q;
	logic        out_valid_q;
	logic        frame_ok_q;
	logic [7:0]  msg_type_q;
	logic [31:0] msg_value_q;

	logic        out_free;
	logic        can_go;
	logic        pop_term;
	logic [31:0] digit32;
	logic [7:0]  type_nx;
	logic [31:0] value_nx;
	logic        check_ok;

	assign out_free = !out_valid_q || !out_stall;
	assign can_go   = head.is_term ? out_free :
	                  ((phase_q == PH_CHECK) ? res_vld_q : 1'b1);
	assign pop      = q_stat.not_empty && can_go;
	assign pop_term = pop && head.is_term;

	assign digit32  = {{23{head.digit[8]}}, head.digit};
	assign type_nx  = (type_q << 3) + (type_q << 1) + head.digit[7:0];
	assign value_nx = (value_q << 3) + (value_q << 1) + digit32;
	assign check_ok = (head.digit == {5'b0, res_q});

	assign out_valid = out_valid_q;
	assign frame_ok  = frame_ok_q;
	assign msg_type  = msg_type_q;
	assign msg_value = msg_value_q;

	assign status.pop_term  = pop_term;
	assign status.check_pop = pop && !head.is_term && (phase_q == PH_CHECK);
	assign status.res_vld   = res_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_TYPE;
			type_q    <= '0;
			value_q   <= '0;
			sum_vld_q <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			res_vld_q <= pop_term ? 1'b0 : sum_vld_q;
			if (pop_term) begin
				phase_q   <= PH_TYPE;
				type_q    <= '0;
				value_q   <= '0;
				sum_vld_q <= 1'b0;
			end else if (pop) begin
				case (phase_q)
					PH_TYPE: begin
						if (head.is_colon) begin
							phase_q <= PH_VALUE;
						end else begin
							type_q <= type_nx;
						end
					end
					PH_VALUE: begin
						if (head.is_colon) begin
							phase_q   <= PH_CHECK;
							sum_vld_q <= 1'b1;
						end else begin
							value_q <= value_nx;
						end
					end
					PH_CHECK: begin
						phase_q <= check_ok ? PH_END : PH_FAULT;
					end
					default: begin
						phase_q <= PH_FAULT;
					end
				endcase
			end
		end
	end

	// residue pipeline: sum captured at the second colon, reduced next cycle
	always_ff @(posedge clk) begin
		if (pop && !head.is_term && head.is_colon && (phase_q == PH_VALUE)) begin
			sum_q <= {24'b0, type_q} + value_q;
		end
		res_q <= drfp_pkg::mod10(sum_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop_term) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_term) begin
			frame_ok_q  <= (phase_q == PH_END);
			msg_type_q  <= type_q;
			msg_value_q <= value_q;
		end
	end

endmodule

// ===== design/decimal_reply_frame_parser_core.sv =====
// ----------------------------------------------------------------------------
// decimal_reply_frame_parser_core
// Parses "type:value:c" reply frames ended by a zero byte, one byte per
// request, and returns one result request per frame.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------
//  in      | in_valid / in_stall  | rx_byte[7:0]
//  out     | out_valid / out_stall| frame_ok, msg_type[7:0], msg_value[31:0]
//
// One byte is taken per cycle while in_stall is low. The byte right after the
// second colon waits in the queue until the checksum residue is ready; the
// residue pipeline (sum, then mod-10 fold) and a stalled output set the only
// extra delay. A result is registered when its terminator leaves the queue.
// arst_n clears the phase, the accumulators, the queue and all valid flags.
// A stalled output holds its result while the queue keeps filling; the input
// stalls only once the front register and the queue are both full.
// ----------------------------------------------------------------------------
module decimal_reply_frame_parser_core #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        frame_ok,
	output logic [7:0]  msg_type,
	output logic [31:0] msg_value
);

	// front to queue
	logic                 push;
	drfp_pkg::item_t      push_item;
	drfp_pkg::q_stat_t    q_stat;

	// queue to back
	logic                 pop;
	drfp_pkg::item_t      head;
	drfp_pkg::bk_status_t bk_status;

	// classify each byte and hold it until the queue has room
	drfp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.rx_byte   (rx_byte),
		.q_stat    (q_stat),
		.push      (push),
		.item      (push_item)
	);

	// decouple the front from the back, so each side stalls on its own
	drfp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	// run the frame state machine and drive the result register
	drfp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.frame_ok  (frame_ok),
		.msg_type  (msg_type),
		.msg_value (msg_value),
		.status    (bk_status)
	);

`ifndef SYNTH
	// a new result only appears after a terminator left the queue
	a_result_from_term: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(bk_status.pop_term))
		else $error("result raised without a terminator pop");

	// the input stalls only when the queue is full
	a_stall_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> q_stat.full)
		else $error("input stalled with room in the queue");

	// the checksum byte is consumed only once the residue is ready
	a_check_needs_res: assert property (@(posedge clk) disable iff (!arst_n)
		bk_status.check_pop |-> bk_status.res_vld)
		else $error("checksum byte consumed before residue was ready");

	// nothing is popped from an empty queue
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_stat.not_empty)
		else $error("pop from empty queue");
`endif

endmodule

// ===== sim/tb_decimal_reply_frame_parser_core.sv =====
// ----------------------------------------------------------------------------
// tb_decimal_reply_frame_parser_core
// Self-checking bench for the reply frame parser. A short table of directed
// bytes goes first: the empty frame, a good frame, a wrong check digit, a
// byte after the check digit, a cut-off frame and extreme byte values. Random
// frames follow, mostly well formed with random content, some cut short, some
// plain noise. Every taken byte runs through a local parser model, and each
// result request is compared field by field with the oldest expected frame.
// ----------------------------------------------------------------------------
module tb_decimal_reply_frame_parser_core;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [31:0] RADIX        = 32'd10;
	localparam int          ITEM_TARGET  = 1550;
	localparam int          QUIET_LIMIT  = 3000;
	localparam int          HOLD_CYCLES  = 300;
	localparam int          DRAIN_CYCLES = 16;

	typedef enum logic [4:0] {
		AWAIT_TYPE  = 5'b00001,
		AWAIT_VALUE = 5'b00010,
		AWAIT_CHECK = 5'b00100,
		AWAIT_TERM  = 5'b01000,
		IN_FAULT    = 5'b10000
	} parse_phase_t;

	typedef struct packed {
		logic        ok;
		logic [7:0]  typ;
		logic [31:0] val;
	} frame_res_t;

	// One byte request; typed rows carry their frame result written out by hand.
	typedef struct packed {
		logic [7:0] rx;
		logic       typed;
		frame_res_t fixed;
	} byte_req_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic [7:0]  rx_byte   = 8'h00;
	logic        out_stall = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic        frame_ok;
	logic [7:0]  msg_type;
	logic [31:0] msg_value;

	// Parser model state and the frames it still expects to see.
	parse_phase_t phase_q   = AWAIT_TYPE;
	logic [7:0]   type_sum  = 8'h00;
	logic [31:0]  value_sum = 32'h0;
	frame_res_t   pending_frames[$];

	int  bytes_counted = 0;
	int  frames_seen   = 0;
	int  errors        = 0;
	bit  calm          = 1'b0;

	// Directed bytes. Frame results are typed in where they are obvious.
	byte_req_t directed_rows [25] = '{
		'{drfp_pkg::CH_TERM,  1'b1, '{1'b0, 8'd0, 32'd0}},   // empty frame
		'{8'h31,              1'b0, '0},                     // "1:2:3" - good frame
		'{drfp_pkg::CH_COLON, 1'b0, '0},
		'{8'h32,              1'b0, '0},
		'{drfp_pkg::CH_COLON, 1'b0, '0},
		'{8'h33,              1'b0, '0},
		'{drfp_pkg::CH_TERM,  1'b1, '{1'b1, 8'd1, 32'd2}},
		'{drfp_pkg::CH_COLON, 1'b0, '0},                     // "::0" then a stray byte
		'{drfp_pkg::CH_COLON, 1'b0, '0},
		'{8'h30,              1'b0, '0},
		'{8'hFF,              1'b0, '0},
		'{drfp_pkg::CH_TERM,  1'b1, '{1'b0, 8'd0, 32'd0}},
		'{8'h35,              1'b0, '0},                     // "5:9:" - no check digit
		'{drfp_pkg::CH_COLON, 1'b0, '0},
		'{8'h39,              1'b0, '0},
		'{drfp_pkg::CH_COLON, 1'b0, '0},
		'{drfp_pkg::CH_TERM,  1'b1, '{1'b0, 8'd5, 32'd9}},
		'{drfp_pkg::CH_COLON, 1'b0, '0},                     // "::5" - wrong check digit
		'{drfp_pkg::CH_COLON, 1'b0, '0},
		'{8'h35,              1'b0, '0},
		'{drfp_pkg::CH_TERM,  1'b1, '{1'b0, 8'd0, 32'd0}},
		'{8'hFF,              1'b0, '0},                     // extremes, cut before 2nd colon
		'{drfp_pkg::CH_COLON, 1'b0, '0},
		'{8'h80,              1'b0, '0},
		'{drfp_pkg::CH_TERM,  1'b0, '0}
	};

	decimal_reply_frame_parser_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.rx_byte   (rx_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.frame_ok  (frame_ok),
		.msg_type  (msg_type),
		.msg_value (msg_value)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Advance the parser model by one byte; return 1 when a frame closes.
	function automatic bit parse_byte(input logic [7:0] b, output frame_res_t res);
		logic [31:0] d;
		logic [31:0] t_next;
		logic [31:0] sum;
		d   = 32'(b) - 32'(drfp_pkg::CH_ZERO);
		res = '0;
		if (b == drfp_pkg::CH_TERM) begin
			res.ok    = (phase_q == AWAIT_TERM);
			res.typ   = type_sum;
			res.val   = value_sum;
			phase_q   = AWAIT_TYPE;
			type_sum  = '0;
			value_sum = '0;
			return 1'b1;
		end
		case (phase_q)
			AWAIT_TYPE: begin
				if (b == drfp_pkg::CH_COLON) begin
					phase_q = AWAIT_VALUE;
				end else begin
					t_next   = 32'(type_sum) * RADIX + d;
					type_sum = t_next[7:0];
				end
			end
			AWAIT_VALUE: begin
				if (b == drfp_pkg::CH_COLON) begin
					phase_q = AWAIT_CHECK;
				end else begin
					value_sum = value_sum * RADIX + d;
				end
			end
			AWAIT_CHECK: begin
				sum     = 32'(type_sum) + value_sum;
				phase_q = (d == sum % RADIX) ? AWAIT_TERM : IN_FAULT;
			end
			default: begin
				phase_q = IN_FAULT;
			end
		endcase
		return 1'b0;
	endfunction

	// Book a taken byte: count it unless the parser drops it, then predict.
	function automatic void note_accept(input byte_req_t r);
		frame_res_t res;
		bit         closes;
		if (phase_q != IN_FAULT || r.rx == drfp_pkg::CH_TERM) bytes_counted++;
		closes = parse_byte(r.rx, res);
		if (closes) pending_frames.push_back(r.typed ? r.fixed : res);
	endfunction

	// Offer one byte request, maybe after a gap, and hold it until taken.
	task automatic offer(input byte_req_t r);
		if (!calm && $urandom_range(99) < 30) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= r.rx;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		note_accept(r);
	endtask

	task automatic send_plain(input logic [7:0] b);
		offer('{b, 1'b0, '0});
	endtask

	// Field byte: mostly a decimal digit, sometimes any byte but colon or zero.
	function automatic logic [7:0] field_char();
		logic [7:0] c;
		if ($urandom_range(7) == 0) begin
			c = 8'($urandom_range(1, 255));
			if (c == drfp_pkg::CH_COLON) c = drfp_pkg::CH_COLON + 8'd1;
		end else begin
			c = drfp_pkg::CH_ZERO + 8'($urandom_range(9));
		end
		return c;
	endfunction

	task automatic send_frame();
		int          shape;
		int          parts;
		int          slip;
		logic [31:0] residue;
		shape = $urandom_range(99);
		if (shape < 70) begin
			// mostly well-formed frame; long value fields wrap the 32-bit accumulator
			repeat ($urandom_range(0, 3)) send_plain(field_char());
			send_plain(drfp_pkg::CH_COLON);
			repeat (($urandom_range(9) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 5))
				send_plain(field_char());
			send_plain(drfp_pkg::CH_COLON);
			// take the check digit from the model: every earlier byte is already in
			residue = (32'(type_sum) + value_sum) % RADIX;
			slip    = ($urandom_range(99) < 15) ? $urandom_range(1, 9) : 0;
			send_plain(drfp_pkg::CH_ZERO + 8'((residue + 32'(slip)) % RADIX));
			if ($urandom_range(99) < 10)
				repeat ($urandom_range(1, 3)) send_plain(8'($urandom_range(1, 255)));
		end else if (shape < 85) begin
			// cut the frame short after a random number of parts
			parts = $urandom_range(0, 3);
			repeat ($urandom_range(0, 3)) send_plain(field_char());
			if (parts > 0) send_plain(drfp_pkg::CH_COLON);
			if (parts > 1) repeat ($urandom_range(0, 4)) send_plain(field_char());
			if (parts > 2) send_plain(drfp_pkg::CH_COLON);
		end else begin
			// noise; zero bytes in it close frames of their own
			repeat ($urandom_range(1, 8)) send_plain(8'($urandom_range(0, 255)));
		end
		send_plain(drfp_pkg::CH_TERM);
	endtask

	// Compare one result request with the oldest expected frame.
	function automatic void check_frame();
		frame_res_t want;
		frames_seen++;
		if (pending_frames.size() == 0) begin
			$error("unexpected result: frame_ok=%0d msg_type=%0d msg_value=%0d",
				frame_ok, msg_type, msg_value);
			errors++;
			return;
		end
		want = pending_frames.pop_front();
		if (frame_ok !== want.ok) begin
			$error("frame_ok: expected %0d, got %0d", want.ok, frame_ok);
			errors++;
		end
		if (msg_type !== want.typ) begin
			$error("msg_type: expected %0d, got %0d", want.typ, msg_type);
			errors++;
		end
		if (msg_value !== want.val) begin
			$error("msg_value: expected %0d, got %0d", want.val, msg_value);
			errors++;
		end
	endfunction

	// Receiver: check taken results, stall at random, and once hold off long
	// enough that the parser fills up and stalls its input.
	initial begin
		int hold_left;
		bit held_once;
		hold_left = 0;
		held_once = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) check_frame();
			if (!held_once && frames_seen >= 40) begin
				held_once = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) hold_left--;
			out_stall <= (hold_left > 0) || (!calm && $urandom_range(99) < 37);
		end
	end

	// Watchdog: end the run once nothing moves on either side for too long.
	initial begin
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	// Sender and run control.
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i]) offer(directed_rows[i]);
		while (bytes_counted < ITEM_TARGET) begin
			// drop idling on both sides for a stretch in the middle of the run
			calm = (bytes_counted >= 700 && bytes_counted < 900);
			send_frame();
		end
		calm = 1'b0;
		in_valid <= 1'b0;
		while (pending_frames.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
design/drfp_pkg.sv
design/drfp_front.sv
design/drfp_queue.sv
design/drfp_back.sv
design/decimal_reply_frame_parser_core.sv
sim/tb_decimal_reply_frame_parser_core.sv
